[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the FIR convolution filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds in the same cycle as cond.
`define FIR_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Checks that prop holds in the cycle after cond.
`define FIR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[sv/fir_pkg.sv]
// Package with the widths, opcodes and limits of the FIR convolution filter.
package fir_pkg;

    localparam int MAX_TAPS_DEF = 128;
    localparam int DATA_W       = 16;
    localparam int OPCODE_W     = 2;
    localparam int COEF_IDX_W   = 7;
    localparam int TAP_CNT_W    = 8;
    localparam int PROD_W       = 32;
    localparam int OUT_W        = 40;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 8'd100;

    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FLUSH  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_COEF   = 2'd2;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 40'sh80_0000_0000;

endpackage

[sv/fir_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/fir_convolution_filter.sv]
// Top level of the FIR convolution filter, built around one shared multiply-accumulate unit.
// A sample or flush request walks n taps through the RAM read, product and accumulator registers,
// where n is the number of active taps; the single MAC walks one tap per cycle.
// The result then enters the output register once out_stall allows; new requests stall until then.
// A coefficient write is taken only in the idle state and leaves the block idle.
// Reset clears the delay line and tap store through per-entry valid bits and sets tap_count to 100.
`include "assert_macros.svh"

module fir_convolution_filter #(
    parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [fir_pkg::OPCODE_W-1:0]          opcode,
    input  logic                                  first_sample,
    input  logic signed [fir_pkg::DATA_W-1:0]     sample,
    input  logic [fir_pkg::COEF_IDX_W-1:0]        coef_index,
    input  logic signed [fir_pkg::DATA_W-1:0]     coef_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [fir_pkg::OUT_W-1:0]      filtered,
    input  logic                                  cfg_we,
    input  logic [fir_pkg::TAP_CNT_W-1:0]         cfg_wdata
);

    import fir_pkg::*;

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + AW;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                 state_reg,     state_next;
    logic [TAP_CNT_W-1:0]       tap_count_reg, tap_count_next;
    logic [AW-1:0]              head_reg,      head_next;
    logic [AW-1:0]              rptr_reg,      rptr_next;
    logic [CW-1:0]              issue_cnt_reg, issue_cnt_next;
    logic [CW-1:0]              n_reg,         n_next;
    logic [MAX_TAPS-1:0]        dvalid_reg,    dvalid_next;
    logic [MAX_TAPS-1:0]        tvalid_reg,    tvalid_next;
    logic                       s1_v_reg,      s1_v_next;
    logic                       s2_v_reg,      s2_v_next;
    logic                       dv_s1_reg,     dv_s1_next;
    logic                       tv_s1_reg,     tv_s1_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [PROD_W-1:0]   prod_reg,      prod_next;
    logic signed [ACC_W-1:0]    acc_reg,       acc_next;
    logic signed [OUT_W-1:0]    filtered_reg,  filtered_next;

    logic                       in_acc;
    logic [AW-1:0]              new_head;
    logic [CW-1:0]              n_eff;
    logic                       dl_we;
    logic signed [DATA_W-1:0]   dl_wdata;
    logic                       tap_we;
    logic [AW-1:0]              tap_waddr;
    logic [AW-1:0]              tap_raddr;
    logic signed [DATA_W-1:0]   dl_rdata;
    logic signed [DATA_W-1:0]   tap_rdata;
    logic signed [DATA_W-1:0]   mul_a;
    logic signed [DATA_W-1:0]   mul_b;
    logic signed [OUT_W-1:0]    acc_sat;

    fir_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_TAPS),
        .AW    (AW)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (new_head),
        .wdata (dl_wdata),
        .raddr (rptr_reg),
        .rdata (dl_rdata)
    );

    fir_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_TAPS),
        .AW    (AW)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (tap_waddr),
        .wdata (coef_value),
        .raddr (tap_raddr),
        .rdata (tap_rdata)
    );

    generate
        if (ACC_W > OUT_W)
        begin : g_sat
            localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
            localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

            always_comb
            begin
                if (acc_reg > SAT_HI)
                begin
                    acc_sat = OUT_MAX;
                end
                else if (acc_reg < SAT_LO)
                begin
                    acc_sat = OUT_MIN;
                end
                else
                begin
                    acc_sat = acc_reg[OUT_W-1:0];
                end
            end
        end
        else
        begin : g_ext
            assign acc_sat = OUT_W'(acc_reg);
        end
    endgenerate

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign new_head  = (head_reg == '0) ? LAST_ADDR : head_reg - AW'(1);
    assign tap_waddr = AW'(coef_index);
    assign tap_raddr = issue_cnt_reg[AW-1:0];
    assign dl_we     = in_acc && (opcode inside {OP_SAMPLE, OP_FLUSH});
    assign dl_wdata  = (opcode == OP_SAMPLE) ? sample : '0;
    assign tap_we    = in_acc && (opcode == OP_COEF) && (int'(coef_index) < MAX_TAPS);
    assign mul_a     = dv_s1_reg ? dl_rdata : '0;
    assign mul_b     = tv_s1_reg ? tap_rdata : '0;

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            n_eff = CW'(MAX_TAPS);
        end
        else
        begin
            n_eff = CW'(tap_count_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tap_count_next = cfg_we ? cfg_wdata : tap_count_reg;
        head_next      = head_reg;
        rptr_next      = rptr_reg;
        issue_cnt_next = issue_cnt_reg;
        n_next         = n_reg;
        dvalid_next    = dvalid_reg;
        tvalid_next    = tvalid_reg;
        s1_v_next      = 1'b0;
        s2_v_next      = s1_v_reg;
        dv_s1_next     = dvalid_reg[rptr_reg];
        tv_s1_next     = tvalid_reg[tap_raddr];
        prod_next      = mul_a * mul_b;
        acc_next       = s2_v_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        filtered_next  = filtered_reg;

        if (tap_we)
        begin
            tvalid_next[tap_waddr] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (dl_we)
                begin
                    if ((opcode == OP_SAMPLE) && first_sample)
                    begin
                        dvalid_next = '0;
                    end
                    dvalid_next[new_head] = 1'b1;
                    head_next      = new_head;
                    rptr_next      = new_head;
                    issue_cnt_next = '0;
                    n_next         = n_eff;
                    acc_next       = '0;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue_cnt_reg < n_reg)
                begin
                    s1_v_next      = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                    rptr_next      = (rptr_reg == LAST_ADDR) ? '0 : rptr_reg + AW'(1);
                end
                else if (!s1_v_reg && !s2_v_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    filtered_next  = acc_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_COUNT_RST;
            head_reg      <= '0;
            rptr_reg      <= '0;
            issue_cnt_reg <= '0;
            n_reg         <= '0;
            dvalid_reg    <= '0;
            tvalid_reg    <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_count_reg <= tap_count_next;
            head_reg      <= head_next;
            rptr_reg      <= rptr_next;
            issue_cnt_reg <= issue_cnt_next;
            n_reg         <= n_next;
            dvalid_reg    <= dvalid_next;
            tvalid_reg    <= tvalid_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_s1_reg    <= dv_s1_next;
        tv_s1_reg    <= tv_s1_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        filtered_reg <= filtered_next;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    `FIR_ASSERT_NEXT(a_mac_start, dl_we, (state_reg == ST_RUN) && (issue_cnt_reg == '0), "A sample or flush request did not start the tap walk.")
    `FIR_ASSERT_NEXT(a_coef_idle, in_acc && (opcode == OP_COEF), state_reg == ST_IDLE, "A coefficient write left the idle state.")
    `FIR_ASSERT_IMPLY(a_issue_bound, state_reg == ST_RUN, issue_cnt_reg <= n_reg, "The tap walk ran past the active taps.")
    `FIR_ASSERT_IMPLY(a_done_drained, state_reg == ST_DONE, !s1_v_reg && !s2_v_reg, "The result was ready before the MAC pipeline drained.")

endmodule
